// ----- rtl/cqtu_pkg.sv -----
// ============================================================================
// cqtu_pkg
// Shared types, codes and helpers for the cascading quad timer unit.
// ============================================================================
package cqtu_pkg;

    // Default number of timers in the ring.
    localparam int NUM_TIMERS_DEF = 4;

    // Number of timers whose interrupts are reported.
    localparam int IRQ_W = 4;

    // Prescale phase width, enough for a divide by 1024.
    localparam int PHASE_W = 10;

    // Width of one timer count.
    localparam int COUNT_W = 16;

    // Action codes carried by an input word.
    localparam logic [1:0] ACTION_TICK  = 2'd0;
    localparam logic [1:0] ACTION_READ  = 2'd1;
    localparam logic [1:0] ACTION_WRITE = 2'd2;

    // Prescale select codes.
    localparam logic [1:0] PRESC_DIV1    = 2'd0;
    localparam logic [1:0] PRESC_DIV64   = 2'd1;
    localparam logic [1:0] PRESC_DIV256  = 2'd2;
    localparam logic [1:0] PRESC_DIV1024 = 2'd3;

    // Control word bit positions.
    localparam int CTL_CASCADE_BIT = 2;
    localparam int CTL_IRQ_EN_BIT  = 6;
    localparam int CTL_RUN_BIT     = 7;

    // Count value at which a timer wraps on its next increment.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // One input word.
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  timer_index;
        logic        control_half;
        logic        wide_access;
        logic [31:0] write_data;
    } cqtu_item_t;

    // One result word.
    typedef struct packed {
        logic [31:0]      read_data;
        logic [IRQ_W-1:0] irq_raised;
    } cqtu_result_t;

    // Phase mask for a prescale select: the divisor minus one.
    function automatic logic [PHASE_W-1:0] prescale_mask(input logic [1:0] sel);
        logic [PHASE_W-1:0] mask;
        unique case (sel)
            PRESC_DIV1:    mask = 10'd0;
            PRESC_DIV64:   mask = 10'd63;
            PRESC_DIV256:  mask = 10'd255;
            PRESC_DIV1024: mask = 10'd1023;
            default:       mask = 10'd0;
        endcase
        return mask;
    endfunction

endpackage

// ----- rtl/cqtu_timer_bank.sv -----
// ============================================================================
// cqtu_timer_bank
// Timer state registers with the tick, cascade, read and write logic.
// ============================================================================
module cqtu_timer_bank #(
    parameter int NUM_TIMERS = cqtu_pkg::NUM_TIMERS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_en,
    input  cqtu_pkg::cqtu_item_t   item,
    output cqtu_pkg::cqtu_result_t result
);

    localparam int IDX_W   = $clog2(NUM_TIMERS);
    localparam int PHASE_W = cqtu_pkg::PHASE_W;
    localparam int COUNT_W = cqtu_pkg::COUNT_W;
    localparam int IRQ_N   = (NUM_TIMERS < cqtu_pkg::IRQ_W) ? NUM_TIMERS : cqtu_pkg::IRQ_W;

    // Per-timer state.
    logic [COUNT_W-1:0] count_reg   [NUM_TIMERS];
    logic [COUNT_W-1:0] count_next  [NUM_TIMERS];
    logic [PHASE_W-1:0] phase_reg   [NUM_TIMERS];
    logic [PHASE_W-1:0] phase_next  [NUM_TIMERS];
    logic [1:0]         presc_reg   [NUM_TIMERS];
    logic [1:0]         presc_next  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] cascade_reg, cascade_next;
    logic [NUM_TIMERS-1:0] irq_en_reg, irq_en_next;
    logic [NUM_TIMERS-1:0] run_reg, run_next;

    // Tick evaluation signals.
    logic [PHASE_W-1:0]    phase_inc [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] fire;
    logic [NUM_TIMERS-1:0] all_ones;
    logic [NUM_TIMERS-1:0] origin_wrap;
    logic [NUM_TIMERS-1:0] carry_in;
    logic [NUM_TIMERS-1:0] wrap;

    // Access decode.
    logic             in_range;
    logic [IDX_W-1:0] sel;
    logic [15:0]      sel_ctl;

    // Prescaler advance and terminal count detection for each timer.
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            phase_inc[i]   = (phase_reg[i] + 10'd1) & cqtu_pkg::prescale_mask(presc_reg[i]);
            fire[i]        = run_reg[i] && !cascade_reg[i] && (phase_inc[i] == '0);
            all_ones[i]    = (count_reg[i] == cqtu_pkg::COUNT_MAX);
            origin_wrap[i] = fire[i] && all_ones[i];
        end
    end

    // Cascade carry: a count-up timer steps when the nearest free-running
    // timer behind it wraps and every count-up timer in between wraps too.
    always_comb
    begin
        int  k;
        logic path_ok;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            carry_in[j] = 1'b0;
            path_ok     = cascade_reg[j] && run_reg[j];
            for (int d = 1; d < NUM_TIMERS; d++)
            begin
                k = j - d;
                if (k < 0)
                begin
                    k = k + NUM_TIMERS;
                end
                if (path_ok && origin_wrap[k])
                begin
                    carry_in[j] = 1'b1;
                end
                path_ok = path_ok && cascade_reg[k] && run_reg[k] && all_ones[k];
            end
            wrap[j] = origin_wrap[j] || (carry_in[j] && all_ones[j]);
        end
    end

    // Register access decode.
    always_comb
    begin
        in_range = (32'(item.timer_index) < NUM_TIMERS);
        sel      = IDX_W'(item.timer_index);
        sel_ctl  = '0;
        sel_ctl[1:0]                       = presc_reg[sel];
        sel_ctl[cqtu_pkg::CTL_CASCADE_BIT] = cascade_reg[sel];
        sel_ctl[cqtu_pkg::CTL_IRQ_EN_BIT]  = irq_en_reg[sel];
        sel_ctl[cqtu_pkg::CTL_RUN_BIT]     = run_reg[sel];
    end

    // Next state of every timer.
    always_comb
    begin
        logic [15:0] ctl_word;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            count_next[i] = count_reg[i];
            phase_next[i] = phase_reg[i];
            presc_next[i] = presc_reg[i];
        end
        cascade_next = cascade_reg;
        irq_en_next  = irq_en_reg;
        run_next     = run_reg;
        ctl_word     = (item.wide_access) ? item.write_data[31:16] : item.write_data[15:0];

        if (item_en)
        begin
            unique case (item.action)
                cqtu_pkg::ACTION_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (run_reg[i] && !cascade_reg[i])
                        begin
                            phase_next[i] = phase_inc[i];
                        end
                        if (fire[i] || carry_in[i])
                        begin
                            count_next[i] = count_reg[i] + 16'd1;
                        end
                    end
                end
                cqtu_pkg::ACTION_WRITE:
                begin
                    if (in_range)
                    begin
                        phase_next[sel] = '0;
                        if (!item.control_half || item.wide_access)
                        begin
                            count_next[sel] = item.write_data[15:0];
                        end
                        if (item.control_half || item.wide_access)
                        begin
                            presc_next[sel]   = ctl_word[1:0];
                            cascade_next[sel] = ctl_word[cqtu_pkg::CTL_CASCADE_BIT];
                            irq_en_next[sel]  = ctl_word[cqtu_pkg::CTL_IRQ_EN_BIT];
                            run_next[sel]     = ctl_word[cqtu_pkg::CTL_RUN_BIT];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of the current word.
    always_comb
    begin
        result = '0;
        if (item.action == cqtu_pkg::ACTION_READ && in_range)
        begin
            if (item.control_half && !item.wide_access)
            begin
                result.read_data = {16'h0000, sel_ctl};
            end
            else
            begin
                result.read_data = {(item.wide_access ? sel_ctl : 16'h0000), count_reg[sel]};
            end
        end
        if (item.action == cqtu_pkg::ACTION_TICK)
        begin
            for (int i = 0; i < IRQ_N; i++)
            begin
                result.irq_raised[i] = irq_en_reg[i] && wrap[i];
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= '0;
                phase_reg[i] <= '0;
                presc_reg[i] <= cqtu_pkg::PRESC_DIV64;
            end
            cascade_reg <= '0;
            irq_en_reg  <= '0;
            run_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= count_next[i];
                phase_reg[i] <= phase_next[i];
                presc_reg[i] <= presc_next[i];
            end
            cascade_reg <= cascade_next;
            irq_en_reg  <= irq_en_next;
            run_reg     <= run_next;
        end
    end

    // The prescale phase always stays below its divisor.
    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_phase_chk
        a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
            (phase_reg[g] & ~cqtu_pkg::prescale_mask(presc_reg[g])) == '0)
            else $error("prescale phase beyond its divisor");
    end

    // Interrupts are raised only by ticks.
    a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (item.action != cqtu_pkg::ACTION_TICK) |-> (result.irq_raised == '0))
        else $error("interrupt raised by a register access");

    // Timer 0, when stopped, holds its count across a tick.
    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (item_en && item.action == cqtu_pkg::ACTION_TICK && !run_reg[0])
        |=> $stable(count_reg[0]))
        else $error("stopped timer changed on a tick");

    // Read data appears only on reads.
    a_read_data_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (item.action != cqtu_pkg::ACTION_READ) |-> (result.read_data == '0))
        else $error("read data on a non-read word");

endmodule

// ----- rtl/cascading_quad_timer_unit.sv -----
// ============================================================================
// cascading_quad_timer_unit
// Ring of cascadable 16-bit timers with prescalers, behind one word channel.
// ============================================================================
// Usage: every input word on the item channel is a base clock tick, a
// register read or a register write to one timer; each word yields exactly
// one result word on the result channel with the read data and the set of
// interrupts raised by that word. Both channels use valid and stall: a word
// moves at a clock edge with valid high and stall low.
// A word accepted into the input register passes the timer logic into the
// result register, where the receiver can take it. Throughput is one word per
// cycle while the receiver does not stall, set by the single pass from the
// input register through the timer logic to the result register.
// When the receiver stalls, the result register holds its word and the
// input register keeps one more; only then is item_stall raised.
// Reset clears all counts and control bits, selects divide by 64 on every
// timer and empties both registers; the block takes words right after reset.
// ============================================================================
module cascading_quad_timer_unit #(
    parameter int NUM_TIMERS = cqtu_pkg::NUM_TIMERS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  cqtu_pkg::cqtu_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output cqtu_pkg::cqtu_result_t result
);

    logic                   s1_valid_reg, s1_valid_next;
    cqtu_pkg::cqtu_item_t   s1_item_reg;
    logic                   res_valid_reg, res_valid_next;
    cqtu_pkg::cqtu_result_t res_reg;
    cqtu_pkg::cqtu_result_t bank_result;
    logic                   advance;
    logic                   process;
    logic                   accept;

    // Handshake control for the two register stages.
    always_comb
    begin
        advance        = !res_valid_reg || !result_stall;
        process        = s1_valid_reg && advance;
        item_stall     = s1_valid_reg && !advance;
        accept         = item_valid && !item_stall;
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        res_valid_next = advance ? s1_valid_reg : res_valid_reg;
    end

    // Timer state and the per-word logic.
    cqtu_timer_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_en (process),
        .item    (s1_item_reg),
        .result  (bank_result)
    );

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (process)
        begin
            res_reg <= bank_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- test/cascading_quad_timer_unit_test.sv -----
// ============================================================================
// cascading_quad_timer_unit_test
// Self-checking bench for the cascading quad timer unit. Ticks, register
// reads and register writes go in with random gaps; every result word is
// checked against a timer bank model kept in the bench, while the result
// side stalls at random and once for a long stretch.
// ============================================================================
module cascading_quad_timer_unit_test;

    localparam int         NT           = cqtu_pkg::NUM_TIMERS_DEF;
    localparam logic [1:0] ACTION_NONE  = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         RANDOM_WORDS = 1000;
    localparam int         MAX_PRINTS   = 40;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    cqtu_pkg::cqtu_item_t   item;
    logic                   result_valid;
    logic                   result_stall;
    cqtu_pkg::cqtu_result_t result;

    // Timer bank state as the bench sees it.
    logic [cqtu_pkg::COUNT_W-1:0] tmr_count  [NT];
    logic [1:0]                   tmr_presc  [NT];
    logic                         tmr_casc   [NT];
    logic                         tmr_irq_en [NT];
    logic                         tmr_run    [NT];
    logic [cqtu_pkg::PHASE_W-1:0] tmr_phase  [NT];

    // Result words still owed by the block, oldest first.
    cqtu_pkg::cqtu_result_t pending_results [$];

    int error_count        = 0;
    int result_count       = 0;
    int tick_count         = 0;
    int read_count         = 0;
    int write_count        = 0;
    int unused_count       = 0;
    int irq_count          = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;
    int sent_words         = 0;
    int hold_req           = 0;
    bit tx_idle_on         = 1'b1;
    bit rx_idle_on         = 1'b1;

    cascading_quad_timer_unit #(
        .NUM_TIMERS(NT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Timer bank model
    // ------------------------------------------------------------------

    function automatic void reset_timer_bank();
        for (int i = 0; i < NT; i++)
        begin
            tmr_count[i]  = '0;
            tmr_presc[i]  = cqtu_pkg::PRESC_DIV64;
            tmr_casc[i]   = 1'b0;
            tmr_irq_en[i] = 1'b0;
            tmr_run[i]    = 1'b0;
            tmr_phase[i]  = '0;
        end
    endfunction

    function automatic logic [15:0] control_of(input int t);
        logic [15:0] w;
        w = '0;
        w[1:0]                       = tmr_presc[t];
        w[cqtu_pkg::CTL_CASCADE_BIT] = tmr_casc[t];
        w[cqtu_pkg::CTL_IRQ_EN_BIT]  = tmr_irq_en[t];
        w[cqtu_pkg::CTL_RUN_BIT]     = tmr_run[t];
        return w;
    endfunction

    // A control write always restarts the prescaler.
    function automatic void load_control(input int t, input logic [15:0] w);
        tmr_presc[t]  = w[1:0];
        tmr_casc[t]   = w[cqtu_pkg::CTL_CASCADE_BIT];
        tmr_irq_en[t] = w[cqtu_pkg::CTL_IRQ_EN_BIT];
        tmr_run[t]    = w[cqtu_pkg::CTL_RUN_BIT];
        tmr_phase[t]  = '0;
    endfunction

    // Only the first four timers have an interrupt bit in the result.
    function automatic logic [cqtu_pkg::IRQ_W-1:0] irq_of(input int t);
        logic [cqtu_pkg::IRQ_W-1:0] b;
        b = '0;
        if (t < cqtu_pkg::IRQ_W && tmr_irq_en[t])
            b[t] = 1'b1;
        return b;
    endfunction

    // Timer src has just wrapped: walk the ring of count-up neighbours.
    function automatic logic [cqtu_pkg::IRQ_W-1:0] carry_chain(input int src);
        logic [cqtu_pkg::IRQ_W-1:0] irqs;
        int                         cur;
        int                         nxt;
        logic                       wrapped;
        irqs = irq_of(src);
        cur  = src;
        for (int s = 0; s < NT; s++)
        begin
            nxt = (cur + 1) % NT;
            if (!(tmr_casc[nxt] && tmr_run[nxt]))
                break;
            wrapped        = (tmr_count[nxt] == cqtu_pkg::COUNT_MAX);
            tmr_count[nxt] = tmr_count[nxt] + 1'b1;
            if (!wrapped)
                break;
            irqs |= irq_of(nxt);
            cur = nxt;
        end
        return irqs;
    endfunction

    // Applies one input word to the model and returns the word it owes.
    function automatic cqtu_pkg::cqtu_result_t timer_bank_step(
        input cqtu_pkg::cqtu_item_t w);
        cqtu_pkg::cqtu_result_t       r;
        int                           idx;
        logic [cqtu_pkg::PHASE_W-1:0] mask;
        r   = '0;
        idx = w.timer_index;
        case (w.action)
            cqtu_pkg::ACTION_TICK:
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (tmr_run[i] && !tmr_casc[i])
                    begin
                        case (tmr_presc[i])
                            cqtu_pkg::PRESC_DIV1:   mask = 10'h000;
                            cqtu_pkg::PRESC_DIV64:  mask = 10'h03F;
                            cqtu_pkg::PRESC_DIV256: mask = 10'h0FF;
                            default:                mask = 10'h3FF;
                        endcase
                        tmr_phase[i] = (tmr_phase[i] + 1'b1) & mask;
                        if (tmr_phase[i] == '0)
                        begin
                            if (tmr_count[i] == cqtu_pkg::COUNT_MAX)
                            begin
                                tmr_count[i] = '0;
                                r.irq_raised |= carry_chain(i);
                            end
                            else
                            begin
                                tmr_count[i] = tmr_count[i] + 1'b1;
                            end
                        end
                    end
                end
            end
            cqtu_pkg::ACTION_READ:
            begin
                if (idx < NT)
                begin
                    if (w.control_half && !w.wide_access)
                    begin
                        r.read_data = {16'h0000, control_of(idx)};
                    end
                    else
                    begin
                        r.read_data = {16'h0000, tmr_count[idx]};
                        if (w.wide_access)
                            r.read_data[31:16] = control_of(idx);
                    end
                end
            end
            cqtu_pkg::ACTION_WRITE:
            begin
                if (idx < NT)
                begin
                    if (w.control_half && !w.wide_access)
                    begin
                        load_control(idx, w.write_data[15:0]);
                    end
                    else
                    begin
                        tmr_count[idx] = w.write_data[15:0];
                        tmr_phase[idx] = '0;
                        if (w.wide_access)
                            load_control(idx, w.write_data[31:16]);
                    end
                end
            end
            default:
            begin
                // The unused action code leaves everything alone.
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH %s on result word %0d: got %h, expected %h",
                     field, result_count, got, want);
    endtask

    // Input acceptance and result checking share one process, so a word
    // is always predicted before any result at the same edge is checked.
    always @(posedge clk)
    begin : scoreboard
        cqtu_pkg::cqtu_result_t want;
        if (rst_n)
        begin
            if (item_valid && item_stall)
                input_stall_cycles++;
            if (item_valid && !item_stall)
            begin
                pending_results.push_back(timer_bank_step(item));
                case (item.action)
                    cqtu_pkg::ACTION_TICK:  tick_count++;
                    cqtu_pkg::ACTION_READ:  read_count++;
                    cqtu_pkg::ACTION_WRITE: write_count++;
                    default:                unused_count++;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected word", result.read_data, 32'h0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.read_data !== want.read_data)
                        report_mismatch("read_data", result.read_data, want.read_data);
                    if (result.irq_raised !== want.irq_raised)
                        report_mismatch("irq_raised", {28'h0, result.irq_raised},
                                        {28'h0, want.irq_raised});
                    if (want.irq_raised != '0)
                        irq_count++;
                end
            end
        end
    end

    // Cycle counter and timeout.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d words outstanding",
                 cycle_count, pending_results.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls plus one long hold on request
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : result_sink
        int stall_run;
        int free_run;
        int hold_left;
        int hold_served;
        stall_run    = 0;
        free_run     = 0;
        hold_left    = 0;
        hold_served  = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_req)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_served + 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!rx_idle_on)
            begin
                result_stall <= 1'b0;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
                result_stall <= 1'b1;
            end
            else if (free_run > 0)
            begin
                free_run--;
                result_stall <= 1'b0;
            end
            else
            begin
                free_run     = $urandom_range(0, 12);
                stall_run    = pick_gap();
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic cqtu_pkg::cqtu_item_t make_word(
        input logic [1:0] act, input logic [1:0] idx, input logic ctl,
        input logic wide, input logic [31:0] data);
        cqtu_pkg::cqtu_item_t w;
        w.action       = act;
        w.timer_index  = idx;
        w.control_half = ctl;
        w.wide_access  = wide;
        w.write_data   = data;
        return w;
    endfunction

    function automatic cqtu_pkg::cqtu_item_t random_word();
        return make_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    endfunction

    // Mostly divide by one and running, so that wraps happen often.
    function automatic logic [15:0] random_control();
        logic [15:0] c;
        c = 16'($urandom());
        c[1:0] = ($urandom_range(0, 9) < 7) ? cqtu_pkg::PRESC_DIV1 : 2'($urandom_range(0, 3));
        c[cqtu_pkg::CTL_RUN_BIT] = ($urandom_range(0, 9) < 8);
        return c;
    endfunction

    // Offers one word after an optional gap and waits until it is taken.
    task automatic send_word(input cqtu_pkg::cqtu_item_t w);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (w.action != ACTION_NONE)
            sent_words++;
    endtask

    // Stops offering words until every owed result has arrived.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Loads value and control of one timer in one of the legal forms.
    task automatic program_timer(input int t);
        logic [15:0] ctl;
        logic [15:0] value;
        logic [1:0]  idx;
        ctl   = random_control();
        value = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                            : 16'($urandom());
        idx   = 2'(t);
        case ($urandom_range(0, 2))
            0:
            begin
                send_word(make_word(cqtu_pkg::ACTION_WRITE, idx, 1'($urandom_range(0, 1)),
                                    1'b1, {ctl, value}));
            end
            1:
            begin
                send_word(make_word(cqtu_pkg::ACTION_WRITE, idx, 1'b0, 1'b0,
                                    {16'($urandom()), value}));
                send_word(make_word(cqtu_pkg::ACTION_WRITE, idx, 1'b1, 1'b0,
                                    {16'($urandom()), ctl}));
            end
            default:
            begin
                send_word(make_word(cqtu_pkg::ACTION_WRITE, idx, 1'b1, 1'b0,
                                    {16'($urandom()), ctl}));
                send_word(make_word(cqtu_pkg::ACTION_WRITE, idx, 1'b0, 1'b0,
                                    {16'($urandom()), value}));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state, odd access forms, a full cascade chain and the prescaler.
    task automatic test_reset_and_corner_cases();
        // Reset values: count zero, control selects divide by 64.
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd0, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd3, 1'b1, 1'b0, 32'h0000_0000));
        // The unused action code must return zeros and change nothing.
        send_word(make_word(ACTION_NONE, 2'd2, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // Narrow writes ignore the upper half of the data.
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd0, 1'b0, 1'b0, 32'hABCD_FFFE));
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd0, 1'b1, 1'b0, 32'hA5A5_FFF8));
        // A wide access with the control half set acts as a wide value access.
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd1, 1'b1, 1'b1, 32'h0084_FFFF));
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd2, 1'b0, 1'b1, 32'h00C4_FFFF));
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd3, 1'b0, 1'b1, 32'h00C4_0010));
        // Second tick wraps timers 0, 1 and 2 and carries into timer 3.
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd1, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd2, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd1, 1'b1, 1'b1, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd2, 1'b0, 1'b1, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd3, 1'b0, 1'b1, 32'h0000_0000));
        // Divide by 64, with a value write restarting the prescale phase.
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd0, 1'b1, 1'b0, 32'h0000_0081));
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_TICK, 2'd0, 1'b0, 1'b0, 32'h0000_0000));
        // All ones and all zeros on a wide write.
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd3, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(cqtu_pkg::ACTION_READ, 2'd3, 1'b0, 1'b1, 32'h0000_0000));
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd3, 1'b0, 1'b1, 32'h0000_0000));
    endtask

    // The result side holds off for a long stretch while words keep coming.
    task automatic test_result_backpressure();
        cqtu_pkg::cqtu_item_t w;
        tx_idle_on = 1'b0;
        hold_req <= hold_req + 1;
        send_word(make_word(cqtu_pkg::ACTION_WRITE, 2'd0, 1'b0, 1'b1, 32'h00C0_FFF8));
        repeat (40)
        begin
            w = random_word();
            w.action = ($urandom_range(0, 3) == 0) ? cqtu_pkg::ACTION_READ
                                                   : cqtu_pkg::ACTION_TICK;
            send_word(w);
        end
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    // Programs timers, runs bursts of ticks and reads back, mixed with noise.
    task automatic test_random_sequences(input int target);
        int                   start;
        int                   kind;
        cqtu_pkg::cqtu_item_t w;
        start = sent_words;
        while (sent_words - start < target)
        begin
            kind = $urandom_range(0, 99);
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on <= ($urandom_range(0, 4) != 0);
            if (kind < 75)
            begin
                for (int t = 0; t < NT; t++)
                begin
                    if ($urandom_range(0, 2) != 0)
                        program_timer(t);
                end
                repeat ($urandom_range(4, 40))
                begin
                    w = random_word();
                    w.action = ($urandom_range(0, 6) == 0) ? cqtu_pkg::ACTION_READ
                                                           : cqtu_pkg::ACTION_TICK;
                    send_word(w);
                end
                for (int t = 0; t < NT; t++)
                begin
                    w = random_word();
                    w.action      = cqtu_pkg::ACTION_READ;
                    w.timer_index = 2'(t);
                    send_word(w);
                end
            end
            else if (kind < 92)
            begin
                repeat ($urandom_range(1, 6))
                    send_word(random_word());
            end
            else
            begin
                drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial
    begin : main
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        reset_timer_bank();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_corner_cases();
        drain_results();
        test_result_backpressure();
        test_random_sequences(RANDOM_WORDS);
        drain_results();
        repeat (10) @(posedge clk);

        $display("Run covered %0d ticks, %0d reads, %0d writes, %0d unused-code words;",
                 tick_count, read_count, write_count, unused_count);
        $display("%0d result words checked, %0d with interrupts, input held off %0d cycles.",
                 result_count, irq_count, input_stall_cycles);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
